// ===== hdl/bsqrt_pkg.sv =====
// bsqrt_pkg: shared types and constants for the binary64 square root
// depends on nothing
`timescale 1ns / 1ps
package bsqrt_pkg;
  localparam int unsigned NumSteps = 54;
  localparam int unsigned RemW = 57;
  localparam int unsigned QW = 54;
  localparam logic [63:0] DefaultNan = 64'h7ff8_0000_0000_0000;
  localparam logic [63:0] QuietBit = 64'h0008_0000_0000_0000;

  typedef enum logic [1:0] {
    RndNearest = 2'd0,
    RndZero    = 2'd1,
    RndUp      = 2'd2,
    RndDown    = 2'd3
  } rnd_mode_e;

  // data handed from cell to cell
  typedef struct packed {
    logic          special;   // result already known
    logic [63:0]   spec_bits;
    logic          spec_inv;
    logic [10:0]   exp_out;   // biased exponent minus one
    logic [1:0]    mode;
    logic [107:0]  rad;       // radicand pairs still to consume, msb first
    logic [RemW-1:0] rem;
    logic [QW-1:0] q;
  } stage_t;
endpackage

// ===== hdl/bsqrt_if.sv =====
// bsqrt_if: valid/ready channel carrying one word
// depends on nothing
`timescale 1ns / 1ps
interface bsqrt_if #(parameter int unsigned W = 64);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/bsqrt_cell.sv =====
// bsqrt_cell: one restoring root step, registered
// depends on bsqrt_pkg
`timescale 1ns / 1ps
module bsqrt_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  bsqrt_pkg::stage_t st_i,
  output logic              valid_o,
  output bsqrt_pkg::stage_t st_o
);
  logic              valid_q;
  bsqrt_pkg::stage_t st_d, st_q;
  logic [bsqrt_pkg::RemW-1:0] r2, trial;

  always_comb begin
    st_d = st_i;
    r2 = {st_i.rem[bsqrt_pkg::RemW-3:0], st_i.rad[107:106]};
    trial = {1'b0, st_i.q, 2'b01};
    st_d.rad = {st_i.rad[105:0], 2'b00};
    if (r2 >= trial) begin
      st_d.rem = r2 - trial;
      st_d.q = {st_i.q[bsqrt_pkg::QW-2:0], 1'b1};
    end else begin
      st_d.rem = r2;
      st_d.q = {st_i.q[bsqrt_pkg::QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign valid_o = valid_q;
  assign st_o = st_q;
endmodule

// ===== hdl/bsqrt_unpack.sv =====
// bsqrt_unpack: special cases, subnormal normalize, exponent halving
// depends on bsqrt_pkg
`timescale 1ns / 1ps
module bsqrt_unpack (
  input  logic [63:0]       x_i,
  input  logic [1:0]        mode_i,
  output bsqrt_pkg::stage_t st_o
);
  logic        neg;
  logic [10:0] bexp;
  logic [51:0] frac;
  logic [5:0]  lz;
  logic [52:0] sig;
  logic [12:0] e;      // signed unbiased exponent of sig*2^e
  logic [53:0] sig2;
  logic [12:0] e2, biased;

  always_comb begin
    neg = x_i[63];
    bexp = x_i[62:52];
    frac = x_i[51:0];
    lz = 6'd0;
    for (int i = 0; i < 52; i++) begin
      if (frac[i]) lz = 6'(51 - i);
    end
    if (bexp == 11'd0) begin
      sig = {1'b0, frac} << (lz + 6'd1);
      e = 13'(-1074) - 13'(lz) - 13'd1;
    end else begin
      sig = {1'b1, frac};
      e = 13'(bexp) - 13'd1075;
    end
    if (e[0]) begin
      sig2 = {sig, 1'b0};
      e2 = e - 13'd1;
    end else begin
      sig2 = {1'b0, sig};
      e2 = e;
    end
    biased = $signed(e2) >>> 1;
    biased = biased + 13'd1048;
    st_o.special = 1'b1;
    st_o.spec_inv = 1'b0;
    st_o.spec_bits = x_i;
    st_o.exp_out = biased[10:0];
    st_o.mode = mode_i;
    st_o.rad = {sig2, 54'd0};
    st_o.rem = '0;
    st_o.q = '0;
    if (bexp == 11'h7ff) begin
      if (frac != 52'd0) st_o.spec_bits = x_i | bsqrt_pkg::QuietBit;
      else if (neg) begin
        st_o.spec_bits = bsqrt_pkg::DefaultNan;
        st_o.spec_inv = 1'b1;
      end
    end else if (x_i[62:0] == 63'd0) begin
      st_o.special = 1'b1;
    end else if (neg) begin
      st_o.spec_bits = bsqrt_pkg::DefaultNan;
      st_o.spec_inv = 1'b1;
    end else begin
      st_o.special = 1'b0;
    end
  end
endmodule

// ===== hdl/binary64_square_root.sv =====
// binary64_square_root: top level, unpack, 54-cell root chain, round
// depends on bsqrt_pkg, bsqrt_if, bsqrt_unpack, bsqrt_cell
`timescale 1ns / 1ps
// Usage:
//   operand words arrive on in_if (valid/ready, 64-bit binary64 pattern);
//   results leave on out_if as {root_bits, invalid_flag, inexact_flag},
//   root in data[65:2], invalid in data[1], inexact in data[0].
//   rounding_mode sits at apb address 0 (0 nearest even, 1 toward zero,
//   2 upward, 3 downward); write it only while the block is empty.
// Pipeline: the chain of 54 cells, one per root bit, plus the output
//   register. Throughput: one word per cycle while the receiver on
//   out_if keeps taking results.
// Reset clears all valid bits and rounding_mode to nearest even.
// Stall: the chain advances only when the output register is free or
//   being taken, so a stalled receiver freezes the whole chain and
//   in_if.ready falls; no word is lost.
module binary64_square_root (
  input  logic        clk_i,
  input  logic        rst_ni,
  bsqrt_if.sink       in_if,
  bsqrt_if.source     out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned N = bsqrt_pkg::NumSteps;
  logic [1:0] mode_q;
  logic       en;
  logic       out_valid_q;
  logic [65:0] out_data_q, out_data_d;
  logic              v [N+1];
  bsqrt_pkg::stage_t s [N+1];
  bsqrt_pkg::stage_t last;
  logic [52:0] m;
  logic rbit, sticky, inc;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {30'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 2'd0;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      mode_q <= pwdata[1:0];
    end
  end

  assign en = !out_valid_q || out_if.ready;
  assign in_if.ready = en;

  bsqrt_unpack u_unpack (.x_i(in_if.data[63:0]), .mode_i(mode_q), .st_o(s[0]));
  assign v[0] = in_if.valid;

  for (genvar g = 0; g < N; g++) begin : g_cell
    bsqrt_cell u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
      .valid_i(v[g]), .st_i(s[g]), .valid_o(v[g+1]), .st_o(s[g+1])
    );
  end

  always_comb begin
    last = s[N];
    m = last.q[53:1];
    rbit = last.q[0];
    sticky = last.rem != '0;
    case (last.mode)
      bsqrt_pkg::RndNearest: inc = rbit & (sticky | m[0]);
      bsqrt_pkg::RndUp:      inc = rbit | sticky;
      default:               inc = 1'b0;
    endcase
    if (last.special) begin
      out_data_d = {last.spec_bits, last.spec_inv, 1'b0};
    end else begin
      out_data_d = {({1'b0, last.exp_out, 52'd0} + {11'd0, m} + {63'd0, inc}), 1'b0,
                    rbit | sticky};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data = out_data_q;
endmodule
